[design/dat_pkg.sv]
package dat_pkg;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_RAISED   = 3'd1,
        KIND_UPDATED  = 3'd2,
        KIND_CLEARED  = 3'd3,
        KIND_REJECTED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_RAISE = 2'd0,
        OP_ACK   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EVAL  = 2'd1,
        ST_CLEAR = 2'd2
    } state_t;

    localparam logic [15:0] INTERVAL_RESET = 16'd1000;
    localparam logic [15:0] SEEN_MAX       = 16'hFFFF;
    localparam logic [7:0]  STRENGTH_UNKNOWN = 8'h80;

    // per-cell command from the controller
    typedef struct packed {
        logic        upd;      // refresh the matched cell
        logic        app;      // append into the cell at fill
        logic        del;      // remove the matched cell, shift higher cells down
        logic [31:0] now;
        logic [7:0]  strength;
    } cell_cmd_t;

endpackage

[design/dat_cell.sv]
module dat_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dat_pkg::cell_cmd_t    cmd,
    input  logic                  live,       // index below entry count
    input  logic                  is_fill,    // index equals entry count
    input  logic                  hit_sel,    // this cell is the one selected for update/delete
    input  logic                  shift_in,   // a lower cell is being removed
    // new-record fields
    input  logic [15:0]           new_id,
    input  logic [7:0]            new_type,
    input  logic [KEY_BITS-1:0]   new_key,
    // probe fields
    input  logic [7:0]            probe_type,
    input  logic [KEY_BITS-1:0]   probe_key,
    input  logic [15:0]           probe_id,
    // neighbour above
    input  logic [15:0]           up_id,
    input  logic [7:0]            up_type,
    input  logic [KEY_BITS-1:0]   up_key,
    input  logic [7:0]            up_strength,
    input  logic [31:0]           up_last,
    input  logic [15:0]           up_count,
    input  logic                  up_live,
    output logic [15:0]           id,
    output logic [7:0]            rtype,
    output logic [KEY_BITS-1:0]   key,
    output logic [7:0]            strength,
    output logic [31:0]           last_seen,
    output logic [15:0]           sightings,
    output logic                  key_hit,
    output logic                  id_hit
);
    logic [15:0]         id_reg;
    logic [7:0]          type_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [7:0]          strength_reg;
    logic [31:0]         last_reg;
    logic [15:0]         count_reg;

    assign id         = id_reg;
    assign rtype      = type_reg;
    assign key        = key_reg;
    assign strength   = strength_reg;
    assign last_seen  = last_reg;
    assign sightings  = count_reg;

    assign key_hit = live && type_reg == probe_type && key_reg == probe_key;
    assign id_hit  = live && id_reg == probe_id;

    always_ff @(posedge clk)
    begin
        if (cmd.app && is_fill)
        begin
            id_reg       <= new_id;
            type_reg     <= new_type;
            key_reg      <= new_key;
            strength_reg <= cmd.strength;
            last_reg     <= cmd.now;
            count_reg    <= 16'd1;
        end
        else if (cmd.upd && hit_sel)
        begin
            last_reg <= cmd.now;
            if (count_reg != dat_pkg::SEEN_MAX)
                count_reg <= count_reg + 16'd1;
            if (cmd.strength != dat_pkg::STRENGTH_UNKNOWN)
                strength_reg <= cmd.strength;
        end
        else if (cmd.del && (hit_sel || shift_in) && up_live)
        begin
            // take the record from the cell above
            id_reg       <= up_id;
            type_reg     <= up_type;
            key_reg      <= up_key;
            strength_reg <= up_strength;
            last_reg     <= up_last;
            count_reg    <= up_count;
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

[design/dedup_alert_table_top.sv]
// Deduplicating alert table, up to TABLE_DEPTH records held in a row of cells.
// Input channel: one beat per command (raise, acknowledge, clear all) with
//   in_valid / in_stall; the beat is taken when in_valid is high and
//   in_stall is low.
// Output channel: result beats on out_valid / out_stall, last_result marks
//   the final beat of a command.
// Config channel: cfg_valid / cfg_ready carries update_interval_ms; write
//   only while idle.
// Sequence: a raise or acknowledge is captured, then compared in every cell at
//   once and applied; one command at a time. Clear all emits one beat per
//   record, top record first, or a single beat when the table is empty.
// The output register holds its beat while out_stall is high; the engine
// waits until it is taken before producing the next one.
// Reset empties the table, sets the next id to 1 and the interval to 1000.
// Record fields are not reset; only cells below the fill count are read.
module dedup_alert_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic                 title_present,
    input  logic [7:0]           alert_type,
    input  logic [KEY_BITS-1:0]  ident_key,
    input  logic [7:0]           haptic_pattern,
    input  logic [7:0]           light_pattern,
    input  logic signed [7:0]    signal_strength,
    input  logic [15:0]          target_id,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           event_kind,
    output logic [15:0]          event_id,
    output logic                 last_result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    dat_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [15:0]     nid_reg, nid_next;
    logic [15:0]     interval_reg;

    logic [1:0]          op_reg;
    logic                title_reg;
    logic [7:0]          type_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [7:0]          strength_reg;
    logic [15:0]         target_reg;
    logic [31:0]         now_reg;

    logic        ov_reg, ov_next;
    logic [2:0]  ok_reg, ok_next;
    logic [15:0] oid_reg, oid_next;
    logic        ol_reg, ol_next;

    logic accept, out_free;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = state_reg != dat_pkg::ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = ov_reg;
    assign event_kind  = ok_reg;
    assign event_id    = oid_reg;
    assign last_result = ol_reg;

    // cell row
    logic [15:0]         c_id   [TABLE_DEPTH];
    logic [7:0]          c_type [TABLE_DEPTH];
    logic [KEY_BITS-1:0] c_key  [TABLE_DEPTH];
    logic [7:0]          c_str  [TABLE_DEPTH];
    logic [31:0]         c_last [TABLE_DEPTH];
    logic [15:0]         c_cnt  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] key_hit, id_hit, live, sel, below_sel;
    dat_pkg::cell_cmd_t  cmd;

    // first hit selection
    logic [TABLE_DEPTH-1:0] hits;
    assign hits = (op_reg == dat_pkg::OP_ACK) ? id_hit : key_hit;
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            below_sel[i] = seen;
            sel[i] = hits[i] && !seen;
            seen = seen || hits[i];
        end
    end

    logic          any_hit;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (hits[i])
                hit_idx = IW'(i);
    end
    assign any_hit = |hits;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            localparam int UP = (g + 1 < TABLE_DEPTH) ? g + 1 : g;
            assign live[g] = CW'(g) < count_reg;
            dat_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .live        (live[g]),
                .is_fill     (CW'(g) == count_reg),
                .hit_sel     (sel[g]),
                .shift_in    (below_sel[g]),
                .new_id      (nid_reg),
                .new_type    (type_reg),
                .new_key     (key_reg),
                .probe_type  (type_reg),
                .probe_key   (key_reg),
                .probe_id    (target_reg),
                .up_id       (c_id[UP]),
                .up_type     (c_type[UP]),
                .up_key      (c_key[UP]),
                .up_strength (c_str[UP]),
                .up_last     (c_last[UP]),
                .up_count    (c_cnt[UP]),
                .up_live     ((g + 1 < TABLE_DEPTH) && live[UP]),
                .id          (c_id[g]),
                .rtype       (c_type[g]),
                .key         (c_key[g]),
                .strength    (c_str[g]),
                .last_seen   (c_last[g]),
                .sightings   (c_cnt[g]),
                .key_hit     (key_hit[g]),
                .id_hit      (id_hit[g])
            );
        end
    endgenerate

    logic [IW-1:0] top_idx;
    assign top_idx = IW'(count_reg - CW'(1));

    logic full, hit_raise;
    assign full = count_reg == CW'(TABLE_DEPTH);
    assign hit_raise = any_hit && key_reg != '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dat_pkg::ST_IDLE:
                if (accept && operation != dat_pkg::OP_NONE)
                    state_next = dat_pkg::ST_EVAL;
            dat_pkg::ST_EVAL:
                if (out_free)
                    state_next = (op_reg == dat_pkg::OP_CLEAR && count_reg > CW'(1))
                        ? dat_pkg::ST_CLEAR : dat_pkg::ST_IDLE;
            dat_pkg::ST_CLEAR:
                if (out_free && count_reg == CW'(1))
                    state_next = dat_pkg::ST_IDLE;
            default:
                state_next = dat_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        logic [31:0] gap;
        gap = now_reg - c_last[hit_idx];
        cmd = '0;
        cmd.now = now_reg;
        cmd.strength = strength_reg;
        count_next = count_reg;
        nid_next = nid_reg;
        ov_next = ov_reg && out_stall;
        ok_next = ok_reg;
        oid_next = oid_reg;
        ol_next = ol_reg;
        unique case (state_reg)
            dat_pkg::ST_EVAL:
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    oid_next = '0;
                    ok_next = dat_pkg::KIND_NONE;
                    priority case (op_reg)
                        dat_pkg::OP_RAISE:
                            if (!title_reg)
                                ok_next = dat_pkg::KIND_REJECTED;
                            else if (hit_raise)
                            begin
                                cmd.upd = 1'b1;
                                oid_next = c_id[hit_idx];
                                ok_next = (gap >= {16'd0, interval_reg})
                                    ? dat_pkg::KIND_UPDATED : dat_pkg::KIND_NONE;
                            end
                            else if (full)
                                ok_next = dat_pkg::KIND_REJECTED;
                            else
                            begin
                                cmd.app = 1'b1;
                                count_next = count_reg + CW'(1);
                                oid_next = nid_reg;
                                ok_next = dat_pkg::KIND_RAISED;
                                nid_next = (nid_reg == 16'hFFFF) ? 16'd1 : nid_reg + 16'd1;
                            end
                        dat_pkg::OP_ACK:
                            if (target_reg != '0 && any_hit)
                            begin
                                cmd.del = 1'b1;
                                count_next = count_reg - CW'(1);
                                oid_next = target_reg;
                                ok_next = dat_pkg::KIND_CLEARED;
                            end
                        default:
                            if (count_reg != '0)
                            begin
                                oid_next = c_id[top_idx];
                                ok_next = dat_pkg::KIND_CLEARED;
                                ol_next = count_reg == CW'(1);
                                count_next = count_reg - CW'(1);
                            end
                    endcase
                end
            dat_pkg::ST_CLEAR:
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ok_next = dat_pkg::KIND_CLEARED;
                    oid_next = c_id[top_idx];
                    ol_next = count_reg == CW'(1);
                    count_next = count_reg - CW'(1);
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dat_pkg::ST_IDLE;
            count_reg    <= '0;
            nid_reg      <= 16'd1;
            interval_reg <= dat_pkg::INTERVAL_RESET;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nid_reg   <= nid_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
                interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        oid_reg <= oid_next;
        ol_reg  <= ol_next;
        if (accept)
        begin
            op_reg       <= operation;
            title_reg    <= title_present;
            type_reg     <= alert_type;
            key_reg      <= ident_key;
            strength_reg <= signal_strength;
            target_reg   <= target_id;
            now_reg      <= now_ms;
        end
    end

    logic unused_pat;
    assign unused_pat = ^{haptic_pattern, light_pattern, c_cnt[0], c_type[0], c_key[0]};

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond depth");
    a_nid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nid_reg != 16'd0)
        else $error("next id is zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(oid_reg) && $stable(ok_reg))
        else $error("stalled result changed");
    a_clear_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dat_pkg::ST_CLEAR && out_free |=> count_reg == $past(count_reg) - CW'(1))
        else $error("clear did not drop a record");
endmodule

[tb/tb_dedup_alert_table_top.sv]
module tb_dedup_alert_table_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        dat_pkg::kind_t kind;
        logic [15:0]    id;
        logic           last;
    } alert_event_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic                title_present;
    logic [7:0]          alert_type;
    logic [63:0]         ident_key;
    logic [7:0]          haptic_pattern;
    logic [7:0]          light_pattern;
    logic signed [7:0]   signal_strength;
    logic [15:0]         target_id;
    logic [31:0]         now_ms;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          event_kind;
    logic [15:0]         event_id;
    logic                last_result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [15:0]         cfg_data;

    // shadow of the alert table
    logic [15:0] tbl_id       [DEPTH];
    logic [7:0]  tbl_type     [DEPTH];
    logic [63:0] tbl_key      [DEPTH];
    logic [7:0]  tbl_strength [DEPTH];
    logic [31:0] tbl_last     [DEPTH];
    logic [15:0] tbl_count    [DEPTH];
    int          fill;
    logic [15:0] next_id;
    logic [15:0] interval;

    alert_event_t pending_events[$];
    int           fail_count;
    int           cycle_count;
    bit           gaps_on;
    int           stall_hold;
    logic [31:0]  clock_ms;

    dedup_alert_table_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .title_present   (title_present),
        .alert_type      (alert_type),
        .ident_key       (ident_key),
        .haptic_pattern  (haptic_pattern),
        .light_pattern   (light_pattern),
        .signal_strength (signal_strength),
        .target_id       (target_id),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_kind      (event_kind),
        .event_id        (event_id),
        .last_result     (last_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    initial
    begin
        out_stall  = 1'b0;
        stall_hold = 0;
        forever
        begin
            @(negedge clk);
            if (!gaps_on)
                out_stall = 1'b0;
            else if (stall_hold > 0)
            begin
                out_stall  = 1'b1;
                stall_hold = stall_hold - 1;
            end
            else if ($urandom_range(3) == 0)
            begin
                out_stall  = 1'b1;
                stall_hold = gap_len() - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    // compare each result beat with the oldest expected event
    always @(posedge clk)
    begin
        alert_event_t exp_ev;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected beat: event_kind %0d event_id %0d", event_kind, event_id);
                fail_count++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (event_kind !== exp_ev.kind)
                begin
                    $error("event_kind: expected %0d, actual %0d", exp_ev.kind, event_kind);
                    fail_count++;
                end
                if (event_id !== exp_ev.id)
                begin
                    $error("event_id: expected %0d, actual %0d", exp_ev.id, event_id);
                    fail_count++;
                end
                if (last_result !== exp_ev.last)
                begin
                    $error("last_result: expected %0d, actual %0d", exp_ev.last, last_result);
                    fail_count++;
                end
            end
        end
    end

    function automatic void post_event(dat_pkg::kind_t k, logic [15:0] id, logic last);
        alert_event_t ev;
        ev.kind = k;
        ev.id   = id;
        ev.last = last;
        pending_events.push_back(ev);
    endfunction

    function automatic void apply_raise(logic title, logic [7:0] typ, logic [63:0] key,
                                        logic [7:0] str, logic [31:0] now);
        logic [31:0] elapsed;
        if (!title)
        begin
            post_event(dat_pkg::KIND_REJECTED, 16'd0, 1'b1);
            return;
        end
        if (key != 64'd0)
            for (int i = 0; i < fill; i++)
                if (tbl_type[i] == typ && tbl_key[i] == key)
                begin
                    elapsed     = now - tbl_last[i];
                    tbl_last[i] = now;
                    if (tbl_count[i] != dat_pkg::SEEN_MAX)
                        tbl_count[i]++;
                    if (str != dat_pkg::STRENGTH_UNKNOWN)
                        tbl_strength[i] = str;
                    post_event(elapsed >= {16'd0, interval} ? dat_pkg::KIND_UPDATED
                                                            : dat_pkg::KIND_NONE,
                               tbl_id[i], 1'b1);
                    return;
                end
        if (fill >= DEPTH)
        begin
            post_event(dat_pkg::KIND_REJECTED, 16'd0, 1'b1);
            return;
        end
        tbl_id[fill]       = next_id;
        tbl_type[fill]     = typ;
        tbl_key[fill]      = key;
        tbl_strength[fill] = str;
        tbl_last[fill]     = now;
        tbl_count[fill]    = 16'd1;
        fill++;
        next_id = next_id + 16'd1;
        if (next_id == 16'd0)
            next_id = 16'd1;
        post_event(dat_pkg::KIND_RAISED, tbl_id[fill-1], 1'b1);
    endfunction

    function automatic void apply_ack(logic [15:0] tgt);
        if (tgt != 16'd0)
            for (int i = 0; i < fill; i++)
                if (tbl_id[i] == tgt)
                begin
                    for (int j = i; j + 1 < fill; j++)
                    begin
                        tbl_id[j]       = tbl_id[j+1];
                        tbl_type[j]     = tbl_type[j+1];
                        tbl_key[j]      = tbl_key[j+1];
                        tbl_strength[j] = tbl_strength[j+1];
                        tbl_last[j]     = tbl_last[j+1];
                        tbl_count[j]    = tbl_count[j+1];
                    end
                    fill--;
                    post_event(dat_pkg::KIND_CLEARED, tgt, 1'b1);
                    return;
                end
        post_event(dat_pkg::KIND_NONE, 16'd0, 1'b1);
    endfunction

    function automatic void apply_clear_all();
        if (fill == 0)
        begin
            post_event(dat_pkg::KIND_NONE, 16'd0, 1'b1);
            return;
        end
        while (fill > 0)
        begin
            fill--;
            post_event(dat_pkg::KIND_CLEARED, tbl_id[fill], fill == 0);
        end
    endfunction

    task automatic send_command(dat_pkg::op_t op, logic title, logic [7:0] typ,
                                logic [63:0] key, logic [7:0] str, logic [15:0] tgt,
                                logic [31:0] now);
        if (gaps_on && $urandom_range(3) == 0)
        begin
            in_valid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        operation       = op;
        title_present   = title;
        alert_type      = typ;
        ident_key       = key;
        haptic_pattern  = 8'($urandom_range(255));
        light_pattern   = 8'($urandom_range(255));
        signal_strength = str;
        target_id       = tgt;
        now_ms          = now;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        case (op)
            dat_pkg::OP_RAISE: apply_raise(title, typ, key, str, now);
            dat_pkg::OP_ACK:   apply_ack(tgt);
            dat_pkg::OP_CLEAR: apply_clear_all();
            default:  ;
        endcase
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic raise(logic [7:0] typ, logic [63:0] key, logic [7:0] str, logic [31:0] now);
        send_command(dat_pkg::OP_RAISE, 1'b1, typ, key, str, 16'd0, now);
    endtask

    task automatic drain();
        while (pending_events.size() != 0)
            @(posedge clk);
        // extra wait after the last expected beat has been checked
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_interval(logic [15:0] value);
        drain();
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        interval = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_directed();
        gaps_on = 1'b1;
        send_command(dat_pkg::OP_CLEAR, 1'b1, 8'd0, 64'd0, 8'd0, 16'd0, 32'd0);
        send_command(dat_pkg::OP_RAISE, 1'b0, 8'd1, 64'd5, 8'd0, 16'd0, 32'd0);
        raise(8'd0, 64'd0, 8'h80, 32'd0);
        raise(8'd0, 64'd0, 8'h7F, 32'd1);
        raise(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 32'd100);
        raise(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h7F, 32'd600);
        raise(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 32'd1100);
        raise(8'hFE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'd1100);
        raise(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 32'hFFFF_FFFF);
        send_command(dat_pkg::OP_ACK, 1'b1, 8'd0, 64'd0, 8'd0, 16'd0, 32'd0);
        send_command(dat_pkg::OP_ACK, 1'b1, 8'd0, 64'd0, 8'd0, 16'hFFFF, 32'd0);
        send_command(dat_pkg::OP_ACK, 1'b1, 8'd0, 64'd0, 8'd0, 16'd2, 32'd0);
        send_command(dat_pkg::OP_NONE, 1'b1, 8'hAA, 64'd1, 8'd0, 16'd1, 32'd0);
        send_command(dat_pkg::OP_CLEAR, 1'b1, 8'd0, 64'd0, 8'd0, 16'd0, 32'd0);
        // fill the table, then a new record is refused but a match still lands
        for (int i = 0; i < DEPTH; i++)
            raise(8'h10, 64'd100 + i, 8'd0, 32'd5000);
        raise(8'h10, 64'd999, 8'd0, 32'd5000);
        raise(8'h10, 64'd103, 8'h80, 32'd9000);
        send_command(dat_pkg::OP_ACK, 1'b1, 8'd0, 64'd0, 8'd0, tbl_id[7], 32'd0);
        send_command(dat_pkg::OP_CLEAR, 1'b1, 8'd0, 64'd0, 8'd0, 16'd0, 32'd0);
    endtask

    task automatic test_interval_extremes();
        set_interval(16'd0);
        raise(8'd3, 64'd77, 8'd0, 32'd10);
        raise(8'd3, 64'd77, 8'd0, 32'd10);
        set_interval(16'hFFFF);
        raise(8'd3, 64'd77, 8'd0, 32'd65544);
        raise(8'd3, 64'd77, 8'd0, 32'd65545);
        raise(8'd3, 64'd77, 8'd0, 32'hFFFF_FFF0);
        raise(8'd3, 64'd77, 8'd0, 32'h0000_FFF0);
        send_command(dat_pkg::OP_CLEAR, 1'b1, 8'd0, 64'd0, 8'd0, 16'd0, 32'd0);
        set_interval(dat_pkg::INTERVAL_RESET);
    endtask

    task automatic test_random_traffic();
        logic [63:0] key_pool[4];
        logic [63:0] key;
        logic [7:0]  str;
        int          pick;
        key_pool[0] = 64'd0;
        key_pool[1] = 64'h1;
        key_pool[2] = {$urandom, $urandom};
        key_pool[3] = 64'h8000_0000_0000_0000;
        for (int n = 0; n < 90; n++)
        begin
            if (n == 45)
                set_interval(16'($urandom_range(2000)));
            clock_ms = clock_ms + ($urandom_range(9) == 0 ? $urandom : $urandom_range(1500));
            pick     = $urandom_range(99);
            str      = $urandom_range(3) == 0 ? dat_pkg::STRENGTH_UNKNOWN : 8'($urandom);
            key      = $urandom_range(7) == 0 ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(3)];
            if (pick < 65)
                send_command(dat_pkg::OP_RAISE, $urandom_range(15) != 0,
                             8'($urandom_range(3)), key, str, 16'($urandom), clock_ms);
            else if (pick < 72)
                send_command(dat_pkg::OP_RAISE, 1'b1, 8'($urandom), key, str,
                             16'($urandom), clock_ms);
            else if (pick < 88 && fill > 0)
                send_command(dat_pkg::OP_ACK, 1'b1, 8'd0, 64'd0, 8'd0,
                             tbl_id[$urandom_range(fill - 1)], clock_ms);
            else if (pick < 93)
                send_command(dat_pkg::OP_ACK, 1'b1, 8'($urandom), key, str,
                             16'($urandom), clock_ms);
            else if (pick < 98)
                send_command(dat_pkg::OP_CLEAR, 1'b0, 8'($urandom), key, str,
                             16'($urandom), clock_ms);
            else
                send_command(dat_pkg::OP_NONE, 1'b1, 8'($urandom), key, str,
                             16'($urandom), clock_ms);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = dat_pkg::OP_NONE;
        title_present   = 1'b0;
        alert_type      = 8'd0;
        ident_key       = 64'd0;
        haptic_pattern  = 8'd0;
        light_pattern   = 8'd0;
        signal_strength = 8'sd0;
        target_id       = 16'd0;
        now_ms          = 32'd0;
        cfg_valid       = 1'b0;
        cfg_data        = 16'd0;
        fail_count      = 0;
        cycle_count     = 0;
        gaps_on         = 1'b0;
        fill            = 0;
        next_id         = 16'd1;
        interval        = dat_pkg::INTERVAL_RESET;
        clock_ms        = 32'd20000;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_interval_extremes();
        test_random_traffic();

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
